### src/fmr_pkg.sv
// Shared constants and types for the multitap feedback delay reverb.
// Used by fmr_ctrl, fmr_datapath and feedback_multitap_reverb; depends on nothing.
package fmr_pkg;

    localparam int DEF_BUFFER_DEPTH = 131072;
    localparam int DEF_SAMPLE_WIDTH = 24;

    localparam int GAIN_W         = 16;
    localparam int DELAY_W        = 17;
    localparam int LP_FRAC        = 8;
    localparam int MIN_DEPTH_LOG2 = 10;
    localparam int MOD_STEPS      = DELAY_W - MIN_DEPTH_LOG2 + 1;
    localparam int NUM_TAPS       = 3;
    localparam int TAP_SEL_W      = 2;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = DELAY_W;

    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FB_GAIN     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LP_COEFF    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DELAY_LONG  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_DELAY_MID   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_DELAY_SHORT = 3'd5;

    localparam logic [TAP_SEL_W-1:0] TAP_LONG  = 2'd0;
    localparam logic [TAP_SEL_W-1:0] TAP_MID   = 2'd1;
    localparam logic [TAP_SEL_W-1:0] TAP_SHORT = 2'd2;

    localparam logic                RST_ENABLE      = 1'b1;
    localparam logic [GAIN_W-1:0]   RST_FB_GAIN     = 16'd0;
    localparam logic [GAIN_W-1:0]   RST_LP_COEFF    = 16'd214;
    localparam logic [DELAY_W-1:0]  RST_DELAY_LONG  = 17'd4800;
    localparam logic [DELAY_W-1:0]  RST_DELAY_MID   = 17'd1584;
    localparam logic [DELAY_W-1:0]  RST_DELAY_SHORT = 17'd720;

    typedef struct packed {
        logic                enable;
        logic [GAIN_W-1:0]   fb_gain;
        logic [GAIN_W-1:0]   lp_coeff;
        logic [DELAY_W-1:0]  delay_long;
        logic [DELAY_W-1:0]  delay_mid;
        logic [DELAY_W-1:0]  delay_short;
    } t_cfg;

    typedef struct packed {
        logic in_valid;
        logic out_ready;
        logic enable;
    } t_ctrl_status;

    typedef struct packed {
        logic                 load_out;
        logic                 advance;
        logic                 wr_en;
        logic                 rd_en;
        logic [TAP_SEL_W-1:0] rd_sel;
        logic                 mul_en;
        logic                 acc_clr;
        logic                 acc_en;
        logic                 lp_diff;
        logic                 lp_mul;
        logic                 lp_upd;
    } t_dp_cmd;

endpackage

### src/fmr_ctrl.sv
// Sequencing state machine of the reverb: handshakes and datapath commands.
// Depends on fmr_pkg for the status and command structs.
module fmr_ctrl
    import fmr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_ctrl_status i_status,
    output t_dp_cmd      o_cmd,
    output logic         o_in_ready,
    output logic         o_out_valid
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_WRITE = 10'b0000000010,
        S_RD0   = 10'b0000000100,
        S_RD1   = 10'b0000001000,
        S_RD2   = 10'b0000010000,
        S_MUL   = 10'b0000100000,
        S_ACC   = 10'b0001000000,
        S_LPD   = 10'b0010000000,
        S_LPM   = 10'b0100000000,
        S_LPU   = 10'b1000000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   c_ready;
    logic   c_accept;

    assign c_ready     = (r_state == S_IDLE) && (!r_out_valid || i_status.out_ready);
    assign c_accept    = i_status.in_valid && c_ready;
    assign o_in_ready  = c_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_out_valid = r_out_valid;
        if (c_accept) begin
            n_out_valid = 1'b1;
        end else if (i_status.out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.load_out = c_accept;
        n_state        = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (c_accept && i_status.enable) begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.acc_clr = 1'b1;
                n_state       = S_RD0;
            end
            S_RD0: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = TAP_LONG;
                n_state      = S_RD1;
            end
            S_RD1: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = TAP_MID;
                o_cmd.mul_en = 1'b1;
                n_state      = S_RD2;
            end
            S_RD2: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = TAP_SHORT;
                o_cmd.mul_en = 1'b1;
                o_cmd.acc_en = 1'b1;
                n_state      = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.acc_en = 1'b1;
                n_state      = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc_en = 1'b1;
                n_state      = S_LPD;
            end
            S_LPD: begin
                o_cmd.lp_diff = 1'b1;
                n_state       = S_LPM;
            end
            S_LPM: begin
                o_cmd.lp_mul = 1'b1;
                n_state      = S_LPU;
            end
            S_LPU: begin
                o_cmd.lp_upd = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### src/fmr_datapath.sv
// Datapath of the reverb: delay memory, tap multiply-accumulate and TPT low-pass.
// Depends on fmr_pkg; driven by the command struct from fmr_ctrl.
module fmr_datapath
    import fmr_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH,
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_cfg                           i_cfg,
    input  t_dp_cmd                        i_cmd,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample_out
);

    localparam int SW   = SAMPLE_WIDTH;
    localparam int AW   = $clog2(BUFFER_DEPTH);
    localparam int LW   = SW + LP_FRAC;
    localparam int ACCW = SW + 3;
    localparam int PW   = SW + GAIN_W + 1;
    localparam int LPW  = LW + GAIN_W + 2;

    function automatic logic [AW-1:0] f_delay_mod(input logic [DELAY_W-1:0] d);
        logic [63:0] r;
        r = 64'(d);
        for (int k = MOD_STEPS - 1; k >= 0; k--) begin
            if (r >= (64'(BUFFER_DEPTH) << k)) begin
                r = r - (64'(BUFFER_DEPTH) << k);
            end
        end
        return r[AW-1:0];
    endfunction

    logic [SW-1:0]  mem [BUFFER_DEPTH];

    logic [AW-1:0]  r_wp;
    logic           r_wrapped;
    logic [SW-1:0]  r_wr_data;
    logic [AW-1:0]  r_dmod [NUM_TAPS];
    logic [SW-1:0]  r_rd_data;
    logic           r_rd_ok;
    logic [PW-1:0]  r_tap_prod;
    logic [ACCW-1:0] r_acc;
    logic [LW:0]    r_diff;
    logic [LPW-1:0] r_lp_prod;
    logic [LW-1:0]  r_integ;
    logic [SW-1:0]  r_ffb;
    logic [SW-1:0]  r_out;

    logic [SW:0]     c_mix;
    logic [SW-1:0]   c_wet;
    logic [AW-1:0]   c_wp_next;
    logic [AW-1:0]   c_dsel;
    logic [AW:0]     c_tap_diff;
    logic [AW:0]     c_tap_wrap;
    logic [AW-1:0]   c_tap_pos;
    logic            c_tap_ok;
    logic [SW-1:0]   c_rd_gated;
    logic [PW-1:0]   c_tap_rnd;
    logic [SW:0]     c_tap_val;
    logic [SW-1:0]   c_sum_sat;
    logic [LW-1:0]   c_xs;
    logic [LPW-1:0]  c_lp_rnd;
    logic [LW+1:0]   c_v;
    logic [LW+2:0]   c_y;
    logic [LW+2:0]   c_yv;
    logic [LW-1:0]   c_integ_new;
    logic [LW+2:0]   c_y_rnd;
    logic [SW+2:0]   c_ffb_wide;
    logic [SW-1:0]   c_ffb_new;

    assign c_mix = {i_sample_in[SW-1], i_sample_in} + {r_ffb[SW-1], r_ffb};
    assign c_wet = (c_mix[SW] == c_mix[SW-1]) ? c_mix[SW-1:0]
                                              : {c_mix[SW], {(SW-1){~c_mix[SW]}}};

    assign c_wp_next = (r_wp == AW'(BUFFER_DEPTH - 1)) ? '0 : r_wp + AW'(1);

    assign c_dsel     = r_dmod[i_cmd.rd_sel];
    assign c_tap_diff = {1'b0, r_wp} - {1'b0, c_dsel};
    assign c_tap_wrap = c_tap_diff + (AW + 1)'(BUFFER_DEPTH);
    assign c_tap_pos  = c_tap_diff[AW] ? c_tap_wrap[AW-1:0] : c_tap_diff[AW-1:0];
    assign c_tap_ok   = r_wrapped || ((c_tap_pos != '0) && (c_tap_pos <= r_wp));

    assign c_rd_gated = r_rd_ok ? r_rd_data : '0;
    assign c_tap_rnd  = r_tap_prod + {{(PW-GAIN_W){1'b0}}, 1'b1, {(GAIN_W-1){1'b0}}};
    assign c_tap_val  = c_tap_rnd[PW-1:GAIN_W];

    always_comb begin
        if ((&r_acc[ACCW-1:SW-1]) || !(|r_acc[ACCW-1:SW-1])) begin
            c_sum_sat = r_acc[SW-1:0];
        end else begin
            c_sum_sat = {r_acc[ACCW-1], {(SW-1){~r_acc[ACCW-1]}}};
        end
    end

    assign c_xs     = {c_sum_sat, {LP_FRAC{1'b0}}};
    assign c_lp_rnd = r_lp_prod + {{(LPW-GAIN_W){1'b0}}, 1'b1, {(GAIN_W-1){1'b0}}};
    assign c_v      = c_lp_rnd[LPW-1:GAIN_W];
    assign c_y      = {c_v[LW+1], c_v} + {{3{r_integ[LW-1]}}, r_integ};
    assign c_yv     = c_y + {c_v[LW+1], c_v};

    always_comb begin
        if ((&c_yv[LW+2:LW-1]) || !(|c_yv[LW+2:LW-1])) begin
            c_integ_new = c_yv[LW-1:0];
        end else begin
            c_integ_new = {c_yv[LW+2], {(LW-1){~c_yv[LW+2]}}};
        end
    end

    assign c_y_rnd    = c_y + (LW + 3)'(1 << (LP_FRAC - 1));
    assign c_ffb_wide = c_y_rnd[LW+2:LP_FRAC];

    always_comb begin
        if ((&c_ffb_wide[SW+2:SW-1]) || !(|c_ffb_wide[SW+2:SW-1])) begin
            c_ffb_new = c_ffb_wide[SW-1:0];
        end else begin
            c_ffb_new = {c_ffb_wide[SW+2], {(SW-1){~c_ffb_wide[SW+2]}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[r_wp] <= r_wr_data;
        end else if (i_cmd.rd_en) begin
            r_rd_data <= mem[c_tap_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out <= i_cfg.enable ? c_wet : i_sample_in;
        end
        if (i_cmd.advance) begin
            r_wr_data         <= c_wet;
            r_dmod[TAP_LONG]  <= f_delay_mod(i_cfg.delay_long);
            r_dmod[TAP_MID]   <= f_delay_mod(i_cfg.delay_mid);
            r_dmod[TAP_SHORT] <= f_delay_mod(i_cfg.delay_short);
        end
        if (i_cmd.rd_en) begin
            r_rd_ok <= c_tap_ok;
        end
        if (i_cmd.mul_en) begin
            r_tap_prod <= PW'($signed(c_rd_gated)) * PW'($signed({1'b0, i_cfg.fb_gain}));
        end
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.acc_en) begin
            r_acc <= r_acc + {{2{c_tap_val[SW]}}, c_tap_val};
        end
        if (i_cmd.lp_diff) begin
            r_diff <= {c_xs[LW-1], c_xs} - {r_integ[LW-1], r_integ};
        end
        if (i_cmd.lp_mul) begin
            r_lp_prod <= LPW'($signed(r_diff)) * LPW'($signed({1'b0, i_cfg.lp_coeff}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_wrapped <= 1'b0;
            r_integ   <= '0;
            r_ffb     <= '0;
        end else begin
            if (i_cmd.advance) begin
                r_wp <= c_wp_next;
                if (c_wp_next == '0) begin
                    r_wrapped <= 1'b1;
                end
            end
            if (i_cmd.lp_upd) begin
                r_integ <= c_integ_new;
                r_ffb   <= c_ffb_new;
            end
        end
    end

    assign o_sample_out = r_out;

endmodule

### src/feedback_multitap_reverb.sv
// Top level of the multitap feedback delay reverb: configuration registers and
// the controller and datapath instances. Depends on fmr_pkg, fmr_ctrl, fmr_datapath.
//
//   Channel   Signals                                   Direction
//   input     i_in_valid, o_in_ready, i_sample_in       in
//   output    o_out_valid, i_out_ready, o_sample_out    out
//   config    i_cfg_wr_en, i_cfg_index, i_cfg_wdata     in, write only
//
// With the reverb on a word is taken only after the last is through: the single
// delay memory port serves one write and three tap reads in turn, followed by
// the tap multiply-accumulate and the low-pass difference, multiply and update.
// With the reverb off a word goes straight to the result register and nothing
// else changes. Reset is synchronous and needs no clearing pass; a fill tracker
// makes unwritten memory entries read as zero. The result register frees the
// input side as soon as the waiting result is taken.
module feedback_multitap_reverb
    import fmr_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH,
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample_out,
    input  logic                           i_cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]          i_cfg_wdata
);

    t_cfg         r_cfg;
    t_ctrl_status c_status;
    t_dp_cmd      c_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable      <= RST_ENABLE;
            r_cfg.fb_gain     <= RST_FB_GAIN;
            r_cfg.lp_coeff    <= RST_LP_COEFF;
            r_cfg.delay_long  <= RST_DELAY_LONG;
            r_cfg.delay_mid   <= RST_DELAY_MID;
            r_cfg.delay_short <= RST_DELAY_SHORT;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_ENABLE:      r_cfg.enable      <= i_cfg_wdata[0];
                CFG_FB_GAIN:     r_cfg.fb_gain     <= i_cfg_wdata[GAIN_W-1:0];
                CFG_LP_COEFF:    r_cfg.lp_coeff    <= i_cfg_wdata[GAIN_W-1:0];
                CFG_DELAY_LONG:  r_cfg.delay_long  <= i_cfg_wdata[DELAY_W-1:0];
                CFG_DELAY_MID:   r_cfg.delay_mid   <= i_cfg_wdata[DELAY_W-1:0];
                CFG_DELAY_SHORT: r_cfg.delay_short <= i_cfg_wdata[DELAY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign c_status.in_valid  = i_in_valid;
    assign c_status.out_ready = i_out_ready;
    assign c_status.enable    = r_cfg.enable;

    fmr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_status    (c_status),
        .o_cmd       (c_cmd),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid)
    );

    fmr_datapath #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_cmd        (c_cmd),
        .i_sample_in  (i_sample_in),
        .o_sample_out (o_sample_out)
    );

endmodule

### tb/tb_feedback_multitap_reverb.sv
// Self-checking testbench for feedback_multitap_reverb: drives sample words and register
// writes, predicts every output word with its own model of the echo memory and low-pass.
// Depends on fmr_pkg and the feedback_multitap_reverb RTL.
module tb_feedback_multitap_reverb;
    import fmr_pkg::*;

    localparam int SW = DEF_SAMPLE_WIDTH;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam int RANDOM_PHASES   = 9;
    localparam int WORDS_PER_PHASE = 150;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 12;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int PRINT_LIMIT     = 100;

    typedef logic [SW-1:0] t_sample;

    localparam t_sample S_MAX  = {1'b0, {(SW-1){1'b1}}};
    localparam t_sample S_MIN  = {1'b1, {(SW-1){1'b0}}};
    localparam t_sample S_ONES = '1;

    class reverb_scoreboard;
        bit                 reverb_on;
        bit [GAIN_W-1:0]    tap_gain;
        bit [GAIN_W-1:0]    lp_g;
        bit [DELAY_W-1:0]   tap_delay [NUM_TAPS];
        bit [SW-1:0]        echo_mem [DEF_BUFFER_DEPTH];
        int unsigned        head;
        longint             fb_held;
        longint             lp_state;
        t_sample            wet_words [$];
        int                 errors;

        function new();
            reverb_on            = RST_ENABLE;
            tap_gain             = RST_FB_GAIN;
            lp_g                 = RST_LP_COEFF;
            tap_delay[TAP_LONG]  = RST_DELAY_LONG;
            tap_delay[TAP_MID]   = RST_DELAY_MID;
            tap_delay[TAP_SHORT] = RST_DELAY_SHORT;
            head     = 0;
            fb_held  = 0;
            lp_state = 0;
            errors   = 0;
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_ENABLE:      reverb_on            = val[0];
                CFG_FB_GAIN:     tap_gain             = val[GAIN_W-1:0];
                CFG_LP_COEFF:    lp_g                 = val[GAIN_W-1:0];
                CFG_DELAY_LONG:  tap_delay[TAP_LONG]  = val[DELAY_W-1:0];
                CFG_DELAY_MID:   tap_delay[TAP_MID]   = val[DELAY_W-1:0];
                CFG_DELAY_SHORT: tap_delay[TAP_SHORT] = val[DELAY_W-1:0];
                default: ;
            endcase
        endfunction

        function longint clip(longint v, int bits);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (bits - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) return hi;
            if (v < lo) return lo;
            return v;
        endfunction

        function longint round_off(longint p, int k);
            return (p + (longint'(1) <<< (k - 1))) >>> k;
        endfunction

        function longint scaled_tap(bit [DELAY_W-1:0] delay);
            int unsigned d;
            int unsigned pos;
            longint s;
            d   = delay % DEF_BUFFER_DEPTH;
            pos = (head + DEF_BUFFER_DEPTH - d) % DEF_BUFFER_DEPTH;
            s   = longint'($signed(echo_mem[pos]));
            return round_off(s * longint'(tap_gain), 16);
        endfunction

        function void note_word(t_sample raw);
            longint dry;
            longint y_out;
            longint tap_sum;
            longint v;
            longint y;
            if (!reverb_on) begin
                wet_words.push_back(raw);
                return;
            end
            dry   = longint'($signed(raw));
            y_out = clip(dry + fb_held, SW);
            head  = (head + 1) % DEF_BUFFER_DEPTH;
            echo_mem[head] = y_out[SW-1:0];
            tap_sum = scaled_tap(tap_delay[TAP_LONG]) + scaled_tap(tap_delay[TAP_MID])
                    + scaled_tap(tap_delay[TAP_SHORT]);
            tap_sum  = clip(tap_sum, SW);
            v        = round_off(((tap_sum <<< LP_FRAC) - lp_state) * longint'(lp_g), 16);
            y        = v + lp_state;
            lp_state = clip(y + v, SW + LP_FRAC);
            fb_held  = clip(round_off(y, LP_FRAC), SW);
            wet_words.push_back(y_out[SW-1:0]);
        endfunction

        task report(string msg);
            if (errors < PRINT_LIMIT) $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task check_word(t_sample got);
            t_sample want;
            if (wet_words.size() == 0) begin
                report($sformatf("output word %0d with none expected", $signed(got)));
                return;
            end
            want = wet_words.pop_front();
            if (got !== want)
                report($sformatf("sample_out got %0d, expected %0d",
                                 $signed(got), $signed(want)));
        endtask

        function int pending();
            return wet_words.size();
        endfunction
    endclass

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_in_valid  = 1'b0;
    logic                   o_in_ready;
    t_sample                i_sample_in = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic signed [SW-1:0]   o_sample_out;
    logic                   i_cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata = '0;

    bit idle_on  = 1'b1;
    bit hold_req = 1'b0;

    reverb_scoreboard score = new();

    feedback_multitap_reverb dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_sample_out (o_sample_out),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic send_sample(input t_sample word);
        i_in_valid  <= 1'b1;
        i_sample_in <= word;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        score.note_word(word);
    endtask

    task automatic send_paced(input t_sample word);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        send_sample(word);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        score.set_register(idx, val);
    endtask

    task automatic settle_block();
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (score.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_sample draw_sample();
        case ($urandom_range(0, 9))
            0:       return S_MAX;
            1:       return S_MIN;
            2, 3, 4: return t_sample'($urandom_range(0, 2000)) - t_sample'(1000);
            default: return t_sample'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_fraction();
        logic [CFG_DATA_W-1:0] val;
        val = CFG_DATA_W'($urandom);
        case ($urandom_range(0, 3))
            0:       val[GAIN_W-1:0] = '0;
            1:       val[GAIN_W-1:0] = '1;
            default: ;
        endcase
        return val;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_delay();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return CFG_DATA_W'($urandom);
            default: return CFG_DATA_W'($urandom_range(1, 160));
        endcase
    endfunction

    task automatic pick_settings();
        logic [CFG_DATA_W-1:0] en_word;
        en_word    = CFG_DATA_W'($urandom);
        en_word[0] = ($urandom_range(0, 7) != 0);
        write_reg(CFG_ENABLE, en_word);
        write_reg(CFG_FB_GAIN, pick_fraction());
        write_reg(CFG_LP_COEFF, pick_fraction());
        write_reg(CFG_DELAY_LONG, pick_delay());
        write_reg(CFG_DELAY_MID, pick_delay());
        write_reg(CFG_DELAY_SHORT, pick_delay());
        if ($urandom_range(0, 1) == 1)
            write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO,
                      CFG_DATA_W'($urandom));
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin : result_sink
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready)
            score.check_word(o_sample_out);
    end

    initial begin : stimulus
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // With the reset gain of zero every word comes back unchanged.
        send_sample(S_MAX);
        send_sample(S_MIN);
        send_sample('0);
        send_sample(t_sample'(1));
        send_sample(S_ONES);
        settle_block();

        // Full gain on very short taps drives the feedback into saturation.
        write_reg(CFG_ENABLE, '1);
        write_reg(CFG_FB_GAIN, '1);
        write_reg(CFG_LP_COEFF, CFG_DATA_W'(16'hFFFF));
        write_reg(CFG_DELAY_LONG, CFG_DATA_W'(1));
        write_reg(CFG_DELAY_MID, '0);
        write_reg(CFG_DELAY_SHORT, CFG_DATA_W'(2));
        write_reg(CFG_SPARE_LO, '0);
        write_reg(CFG_SPARE_HI, '1);
        i_cfg_wr_en <= 1'b0;
        repeat (6) send_sample(S_MAX);
        repeat (6) send_sample(S_MIN);
        repeat (2) send_sample('0);
        settle_block();

        write_reg(CFG_ENABLE, CFG_DATA_W'(17'h1FFFE));
        i_cfg_wr_en <= 1'b0;
        send_sample(S_MAX);
        send_sample(S_MIN);
        send_sample(t_sample'(12345));
        settle_block();

        write_reg(CFG_ENABLE, CFG_DATA_W'(1));
        write_reg(CFG_FB_GAIN, CFG_DATA_W'(17'h18000));
        write_reg(CFG_LP_COEFF, '0);
        write_reg(CFG_DELAY_LONG, '1);
        write_reg(CFG_DELAY_MID, CFG_DATA_W'(17'h10000));
        write_reg(CFG_DELAY_SHORT, CFG_DATA_W'(1));
        i_cfg_wr_en <= 1'b0;
        send_sample(S_MAX);
        send_sample(S_MIN);
        send_sample(draw_sample());
        settle_block();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            pick_settings();
            idle_on = (p != RANDOM_PHASES - 1) && (p % 3 != 1);
            if (p == 2) hold_req = 1'b1;
            for (int k = 0; k < WORDS_PER_PHASE; k++) send_paced(draw_sample());
            settle_block();
        end

        if (score.pending() != 0)
            score.report($sformatf("%0d expected words never came out", score.pending()));
        if (score.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin : watchdog
        #5000000;
        $display("tb: failure");
        $finish;
    end

endmodule

### files.f
src/fmr_pkg.sv
src/fmr_ctrl.sv
src/fmr_datapath.sv
src/feedback_multitap_reverb.sv
tb/tb_feedback_multitap_reverb.sv
